/* rtl/sedb_pkg.sv */
package sedb_pkg;

  // fixed field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MagW   = 8;
  localparam int unsigned CoefW  = 9;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned CfgW   = 6;
  localparam int unsigned EdgeW  = 7;
  localparam int unsigned LenW   = 4;
  localparam int unsigned BitCntW = 3;

  // code length before the terminating one is seen
  localparam logic [LenW-1:0] CodeStartLen = 4'd8;
  // last bit position within a byte
  localparam logic [BitCntW-1:0] LastBitPos = 3'd7;
  // block edge after reset
  localparam logic [CfgW-1:0] BlockSizeReset = 6'd4;

  // token from the bit engine to the output stage
  typedef struct packed {
    logic            res;   // a coefficient was completed
    logic            eob;   // last bit of the byte was consumed
    logic            neg;   // stored sign of the coefficient
    logic [MagW-1:0] mag;
    logic [IdxW-1:0] idx;
    logic            last;  // final coefficient of the block
  } sedb_tok_t;

endpackage

/* rtl/signed_expgolomb_block_decoder.sv */
// Signed order-0 Exp-Golomb coefficient block decoder.
// Input channel (in_valid_i / in_ready_o, stream_byte_i): one bitstream byte
// per item, consumed MSB first with no realignment between blocks.
// Output channel (out_valid_o / out_ready_i): one coefficient per item with
// its raster index, a block-last mark and a run-last mark on the final
// coefficient produced by a byte. A byte gives zero to eight coefficients.
// Config channel (cfg_valid_i / cfg_ready_o, block_size_i): block edge; write
// only while no byte is in flight. Always ready.
// Throughput: one bit per cycle through the bit engine while the output
// is not held; the engine reads the sign memory (one synchronous port,
// registered read) at the coefficient counter on every bit. A new byte
// is taken in the cycle the last bit of the previous one is consumed.
// Path: a finished coefficient passes the token register, then waits in
// a pending register until it is known whether a later bit of the same
// byte ends another code, and then moves to the output register.
// Reset: sign phase, counter and code state cleared, block edge 4; the sign
// memory is not cleared and needs no sweep.
// Stall: while the output is held, the bit engine, memory read and pending
// register all freeze; no item is lost or repeated.
module signed_expgolomb_block_decoder #(
  parameter int unsigned MAX_BLOCK_EDGE = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [5:0]        block_size_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        stream_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [8:0] coefficient_o,
  output logic [9:0]        coef_index_o,
  output logic              block_last_o,
  output logic              run_last_o
);
  import sedb_pkg::*;

  localparam int unsigned Depth  = MAX_BLOCK_EDGE * MAX_BLOCK_EDGE;
  localparam int unsigned TotalW = $clog2(Depth + 1);

  logic [TotalW-1:0]   total_q, total_d;
  logic [EdgeW-1:0]    edge_raw;
  logic [EdgeW-1:0]    edge_sat;
  logic [2*EdgeW-1:0]  edge_sq;
  logic                adv;
  sedb_tok_t           tok;

  // coefficient count of a block, worked out on each config write
  assign edge_raw = {1'b0, block_size_i};
  always_comb begin
    edge_sat = edge_raw;
    if (edge_raw == '0) begin
      edge_sat = EdgeW'(1);
    end else if (edge_raw > EdgeW'(MAX_BLOCK_EDGE)) begin
      edge_sat = EdgeW'(MAX_BLOCK_EDGE);
    end
  end
  assign edge_sq     = edge_sat * edge_sat;
  assign total_d     = TotalW'(edge_sq);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalW'(BlockSizeReset * BlockSizeReset);
    end else if (cfg_valid_i) begin
      total_q <= total_d;
    end
  end

  // bit engine with the sign memory
  sedb_engine #(
    .MAX_BLOCK_EDGE (MAX_BLOCK_EDGE),
    .TOTAL_W        (TotalW)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .stream_byte_i (stream_byte_i),
    .total_i       (total_q),
    .tok_o         (tok)
  );

  // pending and output registers
  sedb_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_i         (tok),
    .adv_o         (adv),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coefficient_o (coefficient_o),
    .coef_index_o  (coef_index_o),
    .block_last_o  (block_last_o),
    .run_last_o    (run_last_o)
  );

`ifndef SYNTHESIS
  // a taken byte keeps the engine busy for its remaining bits
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("byte accepted while previous byte still in progress");

  // magnitude never exceeds eight bits
  a_coef_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> coefficient_o != 9'sh100)
    else $error("coefficient out of range");

  // an end-of-byte token is never followed straight away by another
  a_eob_spacing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && tok.eob |=> !tok.eob)
    else $error("end-of-byte marks too close");
`endif

endmodule

/* rtl/sedb_engine.sv */
module sedb_engine #(
  parameter int unsigned MAX_BLOCK_EDGE = 32,
  parameter int unsigned TOTAL_W = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  stream_byte_i,
  input  logic [TOTAL_W-1:0]          total_i,
  output sedb_pkg::sedb_tok_t         tok_o
);
  import sedb_pkg::*;

  localparam int unsigned Depth = MAX_BLOCK_EDGE * MAX_BLOCK_EDGE;
  localparam int unsigned CntW  = $clog2(Depth);

  // bit engine state
  logic [ByteW-1:0]   byte_q, byte_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic               busy_q, busy_d;
  logic               mag_phase_q, mag_phase_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [MagW-1:0]    val_q, val_d;
  logic [LenW-1:0]    nread_q, nread_d;
  logic [LenW-1:0]    len_q, len_d;
  sedb_tok_t          tok_q, tok_d;

  // sign store
  logic               sign_mem [Depth];
  logic               sign_rd_q;
  logic               mem_we;

  logic               step;
  logic               accept;
  logic               cur_bit;
  logic               cnt_done;
  logic [TOTAL_W:0]   cnt_inc;
  logic [MagW-1:0]    val_n;
  logic [LenW-1:0]    nread_n;
  logic [LenW-1:0]    len_n;
  logic [LenW:0]      twice;
  logic               emit;

  assign step       = adv_i && busy_q;
  assign in_ready_o = !busy_q || (adv_i && bit_cnt_q == LastBitPos);
  assign accept     = in_valid_i && in_ready_o;
  assign cur_bit    = byte_q[ByteW-1];

  // end of phase: counter reached or passed the last index
  assign cnt_inc  = (TOTAL_W+1)'(cnt_q) + (TOTAL_W+1)'(1);
  assign cnt_done = cnt_inc >= {1'b0, total_i};

  // exp-golomb bit step
  assign val_n   = {val_q[MagW-2:0], cur_bit};
  assign nread_n = nread_q + LenW'(1);
  assign twice   = {nread_n, 1'b0} - (LenW+1)'(1);
  assign len_n   = (val_n == MagW'(1)) ? twice[LenW-1:0] : len_q;
  assign emit    = nread_n >= len_n;

  assign mem_we = step && !mag_phase_q;

  // next state of the bit engine
  always_comb begin
    byte_d      = byte_q;
    bit_cnt_d   = bit_cnt_q;
    busy_d      = busy_q;
    mag_phase_d = mag_phase_q;
    cnt_d       = cnt_q;
    val_d       = val_q;
    nread_d     = nread_q;
    len_d       = len_q;
    tok_d       = tok_q;
    if (adv_i) begin
      tok_d = '0;
    end
    if (step) begin
      byte_d    = {byte_q[ByteW-2:0], 1'b0};
      bit_cnt_d = bit_cnt_q + BitCntW'(1);
      tok_d.eob = (bit_cnt_q == LastBitPos);
      if (bit_cnt_q == LastBitPos) begin
        busy_d = 1'b0;
      end
      if (!mag_phase_q) begin
        if (cnt_done) begin
          cnt_d       = '0;
          mag_phase_d = 1'b1;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end else begin
        val_d   = val_n;
        nread_d = nread_n;
        len_d   = len_n;
        if (emit) begin
          tok_d.res  = 1'b1;
          tok_d.mag  = val_n - MagW'(1);
          tok_d.idx  = IdxW'(cnt_q);
          tok_d.last = cnt_done;
          val_d      = '0;
          nread_d    = '0;
          len_d      = CodeStartLen;
          if (cnt_done) begin
            cnt_d       = '0;
            mag_phase_d = 1'b0;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end
    end
    if (accept) begin
      byte_d    = stream_byte_i;
      bit_cnt_d = '0;
      busy_d    = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q   <= '0;
      busy_q      <= 1'b0;
      mag_phase_q <= 1'b0;
      cnt_q       <= '0;
      val_q       <= '0;
      nread_q     <= '0;
      len_q       <= CodeStartLen;
      tok_q       <= '0;
    end else begin
      bit_cnt_q   <= bit_cnt_d;
      busy_q      <= busy_d;
      mag_phase_q <= mag_phase_d;
      cnt_q       <= cnt_d;
      val_q       <= val_d;
      nread_q     <= nread_d;
      len_q       <= len_d;
      tok_q       <= tok_d;
    end
  end

  // byte shift register
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // sign memory, read aligned with the token register
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sign_mem[cnt_q] <= cur_bit;
    end
    if (adv_i) begin
      sign_rd_q <= sign_mem[cnt_q];
    end
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.neg = sign_rd_q;
  end

endmodule

/* rtl/sedb_out.sv */
module sedb_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sedb_pkg::sedb_tok_t tok_i,
  output logic                adv_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [8:0]   coefficient_o,
  output logic [9:0]          coef_index_o,
  output logic                block_last_o,
  output logic                run_last_o
);
  import sedb_pkg::*;

  // pending item, held until it is known whether it ends its byte
  logic             p_valid_q, p_valid_d;
  logic             p_fin_q, p_fin_d;
  logic [CoefW-1:0] p_coef_q, p_coef_d;
  logic [IdxW-1:0]  p_idx_q, p_idx_d;
  logic             p_last_q, p_last_d;

  // output register
  logic             o_valid_q, o_valid_d;
  logic [CoefW-1:0] o_coef_q, o_coef_d;
  logic [IdxW-1:0]  o_idx_q, o_idx_d;
  logic             o_last_q, o_last_d;
  logic             o_rl_q, o_rl_d;

  logic             move;
  logic [CoefW-1:0] tok_coef;

  assign adv_o = !o_valid_q || out_ready_i;
  assign move  = p_valid_q && (p_fin_q || tok_i.res || tok_i.eob);

  // apply the stored sign
  assign tok_coef = tok_i.neg ? (CoefW'(0) - {1'b0, tok_i.mag}) : {1'b0, tok_i.mag};

  always_comb begin
    p_valid_d = p_valid_q;
    p_fin_d   = p_fin_q;
    p_coef_d  = p_coef_q;
    p_idx_d   = p_idx_q;
    p_last_d  = p_last_q;
    o_valid_d = o_valid_q;
    o_coef_d  = o_coef_q;
    o_idx_d   = o_idx_q;
    o_last_d  = o_last_q;
    o_rl_d    = o_rl_q;
    if (adv_o) begin
      o_valid_d = move;
      if (move) begin
        o_coef_d  = p_coef_q;
        o_idx_d   = p_idx_q;
        o_last_d  = p_last_q;
        o_rl_d    = p_fin_q || (tok_i.eob && !tok_i.res);
        p_valid_d = 1'b0;
      end
      if (tok_i.res) begin
        p_valid_d = 1'b1;
        p_fin_d   = tok_i.eob;
        p_coef_d  = tok_coef;
        p_idx_d   = tok_i.idx;
        p_last_d  = tok_i.last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_fin_q  <= p_fin_d;
    p_coef_q <= p_coef_d;
    p_idx_q  <= p_idx_d;
    p_last_q <= p_last_d;
    o_coef_q <= o_coef_d;
    o_idx_q  <= o_idx_d;
    o_last_q <= o_last_d;
    o_rl_q   <= o_rl_d;
  end

  assign out_valid_o   = o_valid_q;
  assign coefficient_o = o_coef_q;
  assign coef_index_o  = o_idx_q;
  assign block_last_o  = o_last_q;
  assign run_last_o    = o_rl_q;

endmodule

/* verif/sedb_coef_checker.sv */
`timescale 1ns / 1ps
module sedb_coef_checker #(
  parameter int unsigned MAX_BLOCK_EDGE = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [sedb_pkg::CfgW-1:0]         block_size_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [sedb_pkg::ByteW-1:0]        stream_byte_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [sedb_pkg::CoefW-1:0] coefficient_i,
  input  logic [sedb_pkg::IdxW-1:0]         coef_index_i,
  input  logic                              block_last_i,
  input  logic                              run_last_i,
  output int                                fail_count_o,
  output int                                expected_left_o,
  output logic                              magnitude_phase_o,
  output int                                signs_written_o
);
  import sedb_pkg::*;

  localparam int SignDepth = MAX_BLOCK_EDGE * MAX_BLOCK_EDGE;

  typedef struct packed {
    logic [CoefW-1:0] coef;
    logic [IdxW-1:0]  idx;
    logic             block_last;
    logic             run_last;
  } coef_item_t;

  // coefficients still owed by the block, oldest first
  coef_item_t      expected_coefs[$];

  // decoder state as the block should hold it
  logic            sign_bits [SignDepth];
  logic            mag_phase;
  logic [CfgW-1:0] edge_reg;
  logic [IdxW-1:0] coef_cnt;
  logic [MagW-1:0] code_val;
  logic [LenW-1:0] code_bits;
  logic [LenW-1:0] code_len;
  // sign entries are always written from index zero upwards
  int              signs_written;

  // coefficients per block, with zero and oversized edges clamped
  function automatic int coef_total(input logic [CfgW-1:0] size);
    int edge_len;
    edge_len = (size == '0) ? 1 : int'(size);
    if (edge_len > int'(MAX_BLOCK_EDGE)) edge_len = int'(MAX_BLOCK_EDGE);
    return edge_len * edge_len;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  // walk one byte MSB first and queue every coefficient it completes
  task automatic decode_stream_byte(input logic [ByteW-1:0] byte_val);
    coef_item_t      item;
    coef_item_t      held;
    logic            have_held;
    logic            bit_v;
    logic            ends_block;
    logic [MagW-1:0] mag;
    int              total;
    have_held = 1'b0;
    for (int i = ByteW - 1; i >= 0; i--) begin
      bit_v = byte_val[i];
      total = coef_total(edge_reg);
      if (!mag_phase) begin
        // sign bits, one per coefficient, 1 means negative
        sign_bits[coef_cnt] = bit_v;
        if (int'(coef_cnt) >= signs_written) signs_written = int'(coef_cnt) + 1;
        if (int'(coef_cnt) + 1 >= total) begin
          coef_cnt = '0;
          mag_phase = 1'b1;
        end else begin
          coef_cnt++;
        end
      end else begin
        // exp-golomb magnitude, length fixed by the first one bit
        code_val = {code_val[MagW-2:0], bit_v};
        code_bits++;
        if (code_val == MagW'(1)) code_len = LenW'(2 * code_bits - 1);
        if (code_bits >= code_len) begin
          mag = code_val - MagW'(1);
          ends_block = (int'(coef_cnt) + 1 >= total);
          item.coef = sign_bits[coef_cnt] ? ('0 - {1'b0, mag}) : {1'b0, mag};
          item.idx = coef_cnt;
          item.block_last = ends_block;
          item.run_last = 1'b0;
          if (have_held) expected_coefs.push_back(held);
          held = item;
          have_held = 1'b1;
          code_val = '0;
          code_bits = '0;
          code_len = CodeStartLen;
          if (ends_block) begin
            coef_cnt = '0;
            mag_phase = 1'b0;
          end else begin
            coef_cnt++;
          end
        end
      end
    end
    // the final coefficient of the byte carries the run-last mark
    if (have_held) begin
      held.run_last = 1'b1;
      expected_coefs.push_back(held);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    coef_item_t want;
    if (!rst_ni) begin
      expected_coefs.delete();
      mag_phase = 1'b0;
      edge_reg = BlockSizeReset;
      coef_cnt = '0;
      code_val = '0;
      code_bits = '0;
      code_len = CodeStartLen;
      signs_written = 0;
    end else begin
      // compare each coefficient leaving the block
      if (out_valid_i && out_ready_i) begin
        if (expected_coefs.size() == 0) begin
          report_mismatch($sformatf("unexpected coefficient %0d at index %0d",
                                    coefficient_i, coef_index_i));
        end else begin
          want = expected_coefs.pop_front();
          if (coefficient_i !== want.coef)
            report_mismatch($sformatf("coefficient %0d, want %0d (index %0d)",
                                      coefficient_i, $signed(want.coef), want.idx));
          if (coef_index_i !== want.idx)
            report_mismatch($sformatf("coef_index %0d, want %0d", coef_index_i, want.idx));
          if (block_last_i !== want.block_last)
            report_mismatch($sformatf("block_last %0b, want %0b (index %0d)",
                                      block_last_i, want.block_last, want.idx));
          if (run_last_i !== want.run_last)
            report_mismatch($sformatf("run_last %0b, want %0b (index %0d)",
                                      run_last_i, want.run_last, want.idx));
        end
      end
      if (cfg_valid_i && cfg_ready_i) edge_reg = block_size_i;
      if (in_valid_i && in_ready_i) decode_stream_byte(stream_byte_i);
    end
    expected_left_o = expected_coefs.size();
    magnitude_phase_o = mag_phase;
    signs_written_o = signs_written;
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import sedb_pkg::*;

  localparam int unsigned MaxEdge = 32;
  localparam int ItemTarget = 430;
  localparam int DrainPad = 32;
  localparam int LongHold = 400;
  localparam int CycleLimit = 500000;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CfgW-1:0]         block_size;
  logic                    in_valid;
  logic                    in_ready;
  logic [ByteW-1:0]        stream_byte;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [CoefW-1:0] coefficient;
  logic [IdxW-1:0]         coef_index;
  logic                    block_last;
  logic                    run_last;

  int   fail_count;
  int   expected_left;
  logic magnitude_phase;
  int   signs_written;

  int   bytes_taken = 0;
  int   cycle_count = 0;
  logic calm;

  logic [ByteW-1:0] opening_bytes[$] = '{
    8'hF0, 8'h0F, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h40, 8'h80,
    8'h55, 8'hAA, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h3C};

  signed_expgolomb_block_decoder #(
    .MAX_BLOCK_EDGE(MaxEdge)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .block_size_i (block_size),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .stream_byte_i(stream_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .coefficient_o(coefficient),
    .coef_index_o (coef_index),
    .block_last_o (block_last),
    .run_last_o   (run_last)
  );

  sedb_coef_checker #(
    .MAX_BLOCK_EDGE(MaxEdge)
  ) checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .block_size_i     (block_size),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .stream_byte_i    (stream_byte),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .coefficient_i    (coefficient),
    .coef_index_i     (coef_index),
    .block_last_i     (block_last),
    .run_last_i       (run_last),
    .fail_count_o     (fail_count),
    .expected_left_o  (expected_left),
    .magnitude_phase_o(magnitude_phase),
    .signs_written_o  (signs_written)
  );

  // no random gaps before items and no random receiver stalls through this stretch of items
  assign calm = (bytes_taken >= 260) && (bytes_taken < 320);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // mostly random bytes, with runs of zeros, ones and single set bits for long codes
  function automatic logic [ByteW-1:0] random_stream_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 14) return 8'hFF;
    if (r < 32) return 8'h01 << $urandom_range(0, 7);
    return ByteW'($urandom_range(0, 255));
  endfunction

  // offer one item, with an occasional gap in front of it
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 25) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_taken++;
  endtask

  // stop offering and wait until every coefficient is out and the block is quiet
  task automatic drain_coefs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (DrainPad) @(negedge clk);
  endtask

  // write the block edge while idle; a larger block is only allowed mid-magnitudes
  // when all of its sign entries have been written before
  task automatic program_size(input logic [CfgW-1:0] size);
    int edge_len;
    edge_len = (size == '0) ? 1 : int'(size);
    if (edge_len > int'(MaxEdge)) edge_len = int'(MaxEdge);
    drain_coefs();
    while (magnitude_phase && edge_len * edge_len > signs_written) begin
      send_byte(random_stream_byte());
      drain_coefs();
    end
    @(negedge clk);
    cfg_valid <= 1'b1;
    block_size <= size;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls plus two long hold-offs while items keep coming
  initial begin : receiver
    int hold_marks[2];
    int next_hold;
    int hold_left;
    hold_marks[0] = 200;
    hold_marks[1] = 360;
    next_hold = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && next_hold < 2 && hold_left == 0 && bytes_taken >= hold_marks[next_hold]) begin
        hold_left = LongHold;
        next_hold++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  initial begin : stimulus
    int size_pick;
    int burst;
    logic [CfgW-1:0] size;
    cfg_valid = 1'b0;
    block_size = '0;
    in_valid = 1'b0;
    stream_byte = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // opening items at the reset edge of four: both signs, eight-zero code,
    // eight one-bit codes in a byte, the longest code
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    // zero size acts as edge one
    program_size(6'd0);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h00);
    program_size(6'd1);
    send_byte(8'hFF);
    send_byte(8'h7F);

    // widest block, then an oversized value, then a shrink part-way through
    program_size(6'd63);
    repeat (136) send_byte(random_stream_byte());
    program_size(6'd33);
    repeat (6) send_byte(random_stream_byte());
    program_size(6'd2);

    // random phases, mostly small blocks
    while (bytes_taken < ItemTarget) begin
      size_pick = $urandom_range(0, 99);
      if (size_pick < 10) size = '0;
      else if (size_pick < 70) size = CfgW'($urandom_range(1, 4));
      else if (size_pick < 85) size = CfgW'($urandom_range(5, 10));
      else if (size_pick < 92) size = 6'd63;
      else size = CfgW'($urandom_range(11, 40));
      program_size(size);
      burst = $urandom_range(10, 36);
      for (int n = 0; n < burst && bytes_taken < ItemTarget; n++)
        send_byte(random_stream_byte());
    end

    drain_coefs();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sedb_pkg.sv
rtl/sedb_engine.sv
rtl/sedb_out.sv
rtl/signed_expgolomb_block_decoder.sv
verif/sedb_coef_checker.sv
verif/tb_top.sv
